// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the software timer table
// Field widths, operation codes, status codes and default table size.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int FUNC_W  = 3;
  localparam int TIME_W  = 48;
  localparam int IVAL_W  = 32;
  localparam int ID_W    = 31;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROCESS = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REARM   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NEAREST = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } slot_entry_t;

endpackage : stt_pkg
`default_nettype wire

// ===== src/stt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_if: request and response channels of the software timer table
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface stt_req_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::FUNC_W-1:0]  func;
  logic [stt_pkg::TIME_W-1:0]  now_ms;
  logic [stt_pkg::IVAL_W-1:0]  interval_ms;
  logic [stt_pkg::ID_W-1:0]    timer_id;

  modport source (output valid, func, now_ms, interval_ms, timer_id, input ready);
  modport sink   (input valid, func, now_ms, interval_ms, timer_id, output ready);
endinterface : stt_req_if

interface stt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::STAT_W-1:0]  status;
  logic [stt_pkg::ID_W-1:0]    result_id;
  logic [stt_pkg::TIME_W-1:0]  deadline_ms;
  logic                        last;

  modport source (output valid, status, result_id, deadline_ms, last, input ready);
  modport sink   (input valid, status, result_id, deadline_ms, last, output ready);
endinterface : stt_rsp_if
`default_nettype wire

// ===== src/software_timer_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_top: table of one-shot millisecond timers
// Add, delete, rearm, process expired and nearest query over a slot memory.
// ----------------------------------------------------------------------------
// channel | direction | payload
// req     | in        | func, now_ms, interval_ms, timer_id
// rsp     | out       | status, result_id, deadline_ms, last
//
// Every defined operation scans the slot memory one slot per cycle and then
// answers through the response handshake. A process request repeats the scan
// once per expired timer, so k results take k + 1 scans.
// Reset clears valid and fired flags at once; the slot memory needs no clearing.
// A stalled response holds the block; no request is taken until it drains.
// ----------------------------------------------------------------------------
module software_timer_table_top #(
  parameter int SLOTS = stt_pkg::SLOTS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  stt_req_if.sink    req,
  stt_rsp_if.source  rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [IW-1:0] cnt;
  logic p_valid;
  logic [IW-1:0] p_idx;

  stt_pkg::slot_entry_t mem [SLOTS];
  stt_pkg::slot_entry_t rd_q;

  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] slot_fired;
  logic [stt_pkg::ID_W-1:0] id_counter;

  logic [stt_pkg::FUNC_W-1:0] op;
  logic [stt_pkg::TIME_W-1:0] now_r;
  logic [stt_pkg::IVAL_W-1:0] ival_r;
  logic [stt_pkg::ID_W-1:0]   tid_r;

  logic found;
  logic [IW-1:0] best_idx;
  logic [stt_pkg::ID_W-1:0]   best_id;
  logic [stt_pkg::TIME_W-1:0] best_dl;

  logic pend_valid;
  logic [stt_pkg::ID_W-1:0]   pend_id;
  logic [stt_pkg::TIME_W-1:0] pend_dl;
  logic resume;

  logic out_valid;
  logic [stt_pkg::STAT_W-1:0] out_status;
  logic [stt_pkg::ID_W-1:0]   out_id;
  logic [stt_pkg::TIME_W-1:0] out_dl;
  logic out_last;

  logic [stt_pkg::TIME_W:0]   dl_sum;
  logic [stt_pkg::TIME_W-1:0] new_dl;
  logic hit;
  logic sv, sf;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.result_id   = out_id;
  assign rsp.deadline_ms = out_dl;
  assign rsp.last        = out_last;

  // Saturating deadline: a sum past the 48-bit range never expires.
  assign dl_sum = {1'b0, now_r} + {(stt_pkg::TIME_W + 1 - stt_pkg::IVAL_W)'(0), ival_r};
  assign new_dl = dl_sum[stt_pkg::TIME_W] ? '1 : dl_sum[stt_pkg::TIME_W-1:0];

  always_comb begin
    sv  = slot_valid[p_idx];
    sf  = slot_fired[p_idx];
    hit = 1'b0;
    unique case (op)
      stt_pkg::FUNC_ADD:     hit = !sv && !found;
      stt_pkg::FUNC_DELETE,
      stt_pkg::FUNC_REARM:   hit = sv && (rd_q.id == tid_r) && !found;
      // Scan runs upward, so an equal id in a later slot is never newer.
      stt_pkg::FUNC_PROCESS: hit = sv && !sf && (now_r > rd_q.deadline) &&
                                   (!found || rd_q.id > best_id);
      stt_pkg::FUNC_NEAREST: hit = sv && !sf &&
                                   (!found || rd_q.deadline < best_dl ||
                                    (rd_q.deadline == best_dl && rd_q.id > best_id));
      default:               hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      rd_q <= mem[cnt];
    end
    if (state == S_FIN && found) begin
      if (op == stt_pkg::FUNC_ADD) begin
        mem[best_idx] <= '{id: id_counter, deadline: new_dl};
      end else if (op == stt_pkg::FUNC_REARM) begin
        mem[best_idx] <= '{id: best_id, deadline: new_dl};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      p_valid    <= 1'b0;
      slot_valid <= '0;
      slot_fired <= '0;
      id_counter <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      resume     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      p_valid <= (state == S_SCAN);
      p_idx   <= cnt;
      if (p_valid && hit) begin
        found    <= 1'b1;
        best_idx <= p_idx;
        best_id  <= rd_q.id;
        best_dl  <= rd_q.deadline;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op     <= req.func;
            now_r  <= req.now_ms;
            ival_r <= req.interval_ms;
            tid_r  <= req.timer_id;
            cnt    <= '0;
            found  <= 1'b0;
            pend_valid <= 1'b0;
            if (req.func <= stt_pkg::FUNC_NEAREST) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: state <= S_FIN;
        S_FIN: begin
          unique case (op)
            stt_pkg::FUNC_ADD: begin
              if (found) begin
                slot_valid[best_idx] <= 1'b1;
                slot_fired[best_idx] <= 1'b0;
                id_counter <= id_counter + 1'b1;
                out_status <= stt_pkg::ST_OK;
                out_id     <= id_counter;
                out_dl     <= new_dl;
              end else begin
                out_status <= stt_pkg::ST_FULL;
                out_id     <= '0;
                out_dl     <= '0;
              end
              out_last  <= 1'b1;
              resume    <= 1'b0;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
            stt_pkg::FUNC_DELETE,
            stt_pkg::FUNC_REARM: begin
              if (found) begin
                if (op == stt_pkg::FUNC_DELETE) begin
                  slot_valid[best_idx] <= 1'b0;
                  out_dl <= best_dl;
                end else begin
                  out_dl <= new_dl;
                end
                slot_fired[best_idx] <= 1'b0;
                out_status <= stt_pkg::ST_OK;
                out_id     <= best_id;
              end else begin
                out_status <= stt_pkg::ST_NOT_FOUND;
                out_id     <= tid_r;
                out_dl     <= '0;
              end
              out_last  <= 1'b1;
              resume    <= 1'b0;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
            stt_pkg::FUNC_PROCESS: begin
              // Each result is held until the next pass tells whether it is the last.
              if (found) begin
                slot_fired[best_idx] <= 1'b1;
                pend_valid <= 1'b1;
                pend_id    <= best_id;
                pend_dl    <= best_dl;
                found      <= 1'b0;
                cnt        <= '0;
                if (pend_valid) begin
                  out_status <= stt_pkg::ST_OK;
                  out_id     <= pend_id;
                  out_dl     <= pend_dl;
                  out_last   <= 1'b0;
                  out_valid  <= 1'b1;
                  resume     <= 1'b1;
                  state      <= S_OUT;
                end else begin
                  resume <= 1'b0;
                  state  <= S_SCAN;
                end
              end else begin
                pend_valid <= 1'b0;
                out_status <= pend_valid ? stt_pkg::ST_OK : stt_pkg::ST_NONE;
                out_id     <= pend_valid ? pend_id : '0;
                out_dl     <= pend_valid ? pend_dl : '0;
                out_last   <= 1'b1;
                resume     <= 1'b0;
                out_valid  <= 1'b1;
                state      <= S_OUT;
              end
            end
            default: begin
              out_status <= found ? stt_pkg::ST_OK : stt_pkg::ST_NONE;
              out_id     <= found ? best_id : '0;
              out_dl     <= found ? best_dl : '0;
              out_last   <= 1'b1;
              resume     <= 1'b0;
              out_valid  <= 1'b1;
              state      <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (rsp.ready) begin
            out_valid <= 1'b0;
            state     <= resume ? S_SCAN : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : software_timer_table_top
`default_nettype wire

// ===== src/stt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_checker: port-level checks for the software timer table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module stt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic [stt_pkg::FUNC_W-1:0]  req_func,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [stt_pkg::STAT_W-1:0]  rsp_status,
  input wire logic                        rsp_last
);

  // A pending response is never dropped before its transaction.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before transaction");

  // No request is taken while a response is outstanding.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid)
    else $error("request ready while response pending");

  // One operation at a time: ready drops after each request transaction
  // that carries a defined operation; unused codes are absorbed at once.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func <= stt_pkg::FUNC_NEAREST) |=> !req_ready)
    else $error("request ready right after transaction");

  // Error and empty statuses are always single results.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == stt_pkg::ST_NOT_FOUND || rsp_status == stt_pkg::ST_FULL ||
                  rsp_status == stt_pkg::ST_NONE) |-> rsp_last)
    else $error("error status without last");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule : stt_checker

bind software_timer_table_top stt_checker u_stt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_func   (req.func),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last)
);
`default_nettype wire

// ===== tb/tb_software_timer_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_software_timer_table_top: self-checking bench for the software timer table
// Directed and random add, delete, rearm, process and nearest requests with
// random idling on both channels; a shadow timer table predicts every response.
// ----------------------------------------------------------------------------
module tb_software_timer_table_top;

  localparam int NSLOT = 64;

  typedef struct packed {
    logic [stt_pkg::STAT_W-1:0] status;
    logic [stt_pkg::ID_W-1:0]   id;
    logic [stt_pkg::TIME_W-1:0] deadline;
    logic                       last;
  } timer_rsp_t;

  class timer_table_model;
    bit                         slot_used [NSLOT];
    bit                         slot_done [NSLOT];
    logic [stt_pkg::ID_W-1:0]   slot_tid  [NSLOT];
    logic [stt_pkg::TIME_W-1:0] slot_due  [NSLOT];
    logic [stt_pkg::ID_W-1:0]   next_id;
    timer_rsp_t                 pending [$];
    int                         mismatches;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        slot_used[i] = 0;
        slot_done[i] = 0;
        slot_tid[i]  = '0;
        slot_due[i]  = '0;
      end
      next_id    = '0;
      mismatches = 0;
    endfunction

    function logic [stt_pkg::TIME_W-1:0] due_time(logic [stt_pkg::TIME_W-1:0] now,
                                                  logic [stt_pkg::IVAL_W-1:0] iv);
      logic [stt_pkg::TIME_W:0] sum;
      sum = {1'b0, now} + {17'd0, iv};
      return sum[stt_pkg::TIME_W] ? {stt_pkg::TIME_W{1'b1}} : sum[stt_pkg::TIME_W-1:0];
    endfunction

    function bit is_newer(int a, int b);
      if (slot_tid[a] != slot_tid[b]) return slot_tid[a] > slot_tid[b];
      return a < b;
    endfunction

    function void push(logic [stt_pkg::STAT_W-1:0] st, logic [stt_pkg::ID_W-1:0] id,
                       logic [stt_pkg::TIME_W-1:0] dl, logic lst);
      timer_rsp_t r;
      r.status = st; r.id = id; r.deadline = dl; r.last = lst;
      pending.push_back(r);
    endfunction

    function int find_slot(logic [stt_pkg::ID_W-1:0] id);
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i] && slot_tid[i] == id) return i;
      return -1;
    endfunction

    function void apply_request(logic [stt_pkg::FUNC_W-1:0] f,
                                logic [stt_pkg::TIME_W-1:0] now,
                                logic [stt_pkg::IVAL_W-1:0] iv,
                                logic [stt_pkg::ID_W-1:0] tid);
      int s;
      int best;
      int n;
      bit cand [NSLOT];
      if (f == stt_pkg::FUNC_ADD) begin
        s = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!slot_used[i]) s = i;
        if (s < 0) push(stt_pkg::ST_FULL, '0, '0, 1'b1);
        else begin
          slot_used[s] = 1;
          slot_done[s] = 0;
          slot_tid[s]  = next_id;
          slot_due[s]  = due_time(now, iv);
          next_id      = next_id + 1'b1;
          push(stt_pkg::ST_OK, slot_tid[s], slot_due[s], 1'b1);
        end
      end else if (f == stt_pkg::FUNC_DELETE || f == stt_pkg::FUNC_REARM) begin
        s = find_slot(tid);
        if (s < 0) push(stt_pkg::ST_NOT_FOUND, tid, '0, 1'b1);
        else begin
          if (f == stt_pkg::FUNC_DELETE) slot_used[s] = 0;
          else slot_due[s] = due_time(now, iv);
          slot_done[s] = 0;
          push(stt_pkg::ST_OK, slot_tid[s], slot_due[s], 1'b1);
        end
      end else if (f == stt_pkg::FUNC_PROCESS) begin
        n = 0;
        for (int i = 0; i < NSLOT; i++)
          cand[i] = slot_used[i] && !slot_done[i] && (now > slot_due[i]);
        forever begin
          best = -1;
          for (int i = 0; i < NSLOT; i++)
            if (cand[i] && (best < 0 || is_newer(i, best))) best = i;
          if (best < 0) break;
          cand[best] = 0;
          slot_done[best] = 1;
          push(stt_pkg::ST_OK, slot_tid[best], slot_due[best], 1'b0);
          n++;
        end
        if (n == 0) push(stt_pkg::ST_NONE, '0, '0, 1'b1);
        else pending[pending.size() - 1].last = 1'b1;
      end else if (f == stt_pkg::FUNC_NEAREST) begin
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!slot_used[i] || slot_done[i]) continue;
          if (best < 0 || slot_due[i] < slot_due[best] ||
              (slot_due[i] == slot_due[best] && is_newer(i, best)))
            best = i;
        end
        if (best < 0) push(stt_pkg::ST_NONE, '0, '0, 1'b1);
        else push(stt_pkg::ST_OK, slot_tid[best], slot_due[best], 1'b1);
      end
      // The unused operation codes leave the table alone and answer nothing.
    endfunction

    function void check_response(timer_rsp_t got);
      timer_rsp_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: status %0d id %0d deadline %0d last %0d",
                   got.status, got.id, got.deadline, got.last);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st %0d id %0d dl %0d last %0d, got st %0d id %0d dl %0d last %0d",
                   exp_r.status, exp_r.id, exp_r.deadline, exp_r.last,
                   got.status, got.id, got.deadline, got.last);
      end
    endfunction

    // Id of a random live timer, or a random id that is most likely unknown.
    function logic [stt_pkg::ID_W-1:0] some_id();
      int tries;
      int k;
      if ($urandom_range(0, 4) != 0) begin
        for (tries = 0; tries < 16; tries++) begin
          k = $urandom_range(0, NSLOT - 1);
          if (slot_used[k]) return slot_tid[k];
        end
      end
      return stt_pkg::ID_W'($urandom);
    endfunction
  endclass

  logic clk;
  logic rst;
  stt_req_if req ();
  stt_rsp_if rsp ();

  software_timer_table_top #(.SLOTS(NSLOT)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  timer_table_model table_model;
  bit               quiet_phase;
  logic [stt_pkg::TIME_W-1:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // Response side: check every accepted transaction, stall in random bursts.
  initial begin
    int hold;
    timer_rsp_t got;
    hold = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.status = rsp.status; got.id = rsp.result_id;
        got.deadline = rsp.deadline_ms; got.last = rsp.last;
        table_model.check_response(got);
      end
      if (rst) rsp.ready <= 1'b0;
      else if (quiet_phase) rsp.ready <= 1'b1;
      else if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 16) - 1;
        rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
    end
  end

  task automatic send_request(logic [stt_pkg::FUNC_W-1:0] f,
                              logic [stt_pkg::TIME_W-1:0] now,
                              logic [stt_pkg::IVAL_W-1:0] iv,
                              logic [stt_pkg::ID_W-1:0] tid);
    req.valid       <= 1'b1;
    req.func        <= f;
    req.now_ms      <= now;
    req.interval_ms <= iv;
    req.timer_id    <= tid;
    do @(posedge clk); while (!req.ready);
    table_model.apply_request(f, now, iv, tid);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_responses();
    while (table_model.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [stt_pkg::TIME_W-1:0] now;
    logic [stt_pkg::IVAL_W-1:0] iv;
    clock_ms = clock_ms + $urandom_range(0, 1500);
    now = clock_ms;
    iv  = $urandom_range(0, 3000);
    case ($urandom_range(0, 19))
      0: iv = $urandom;
      1: now = {$urandom, $urandom};
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30)
      send_request(stt_pkg::FUNC_ADD, now, iv, stt_pkg::ID_W'($urandom));
    else if (pick < 45)
      send_request(stt_pkg::FUNC_DELETE, now, iv, table_model.some_id());
    else if (pick < 60)
      send_request(stt_pkg::FUNC_REARM, now, iv, table_model.some_id());
    else if (pick < 80)
      send_request(stt_pkg::FUNC_PROCESS, now, iv, stt_pkg::ID_W'($urandom));
    else if (pick < 96)
      send_request(stt_pkg::FUNC_NEAREST, now, iv, stt_pkg::ID_W'($urandom));
    else
      send_request(stt_pkg::FUNC_W'($urandom_range(5, 7)), now, iv,
                   stt_pkg::ID_W'($urandom));
  endtask

  localparam logic [stt_pkg::TIME_W-1:0] TMAX = {stt_pkg::TIME_W{1'b1}};

  initial begin
    table_model = new();
    quiet_phase = 1'b0;
    clock_ms    = '0;
    rst = 1'b1;
    req.valid = 1'b0; req.func = '0; req.now_ms = '0;
    req.interval_ms = '0; req.timer_id = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table cases first.
    send_request(stt_pkg::FUNC_NEAREST, '0, '0, '0);
    send_request(stt_pkg::FUNC_PROCESS, TMAX, '0, '0);
    send_request(stt_pkg::FUNC_DELETE, '0, '0, {stt_pkg::ID_W{1'b1}});
    send_request(stt_pkg::FUNC_REARM, TMAX, {stt_pkg::IVAL_W{1'b1}}, 31'd5);
    // Zero interval, saturating deadline, and ties on the deadline.
    send_request(stt_pkg::FUNC_ADD, '0, '0, '0);
    send_request(stt_pkg::FUNC_ADD, TMAX, {stt_pkg::IVAL_W{1'b1}}, {stt_pkg::ID_W{1'b1}});
    send_request(stt_pkg::FUNC_ADD, 48'd100, 32'd0, '0);
    send_request(stt_pkg::FUNC_ADD, 48'd50, 32'd50, '0);
    send_request(stt_pkg::FUNC_NEAREST, 48'd0, '0, '0);
    send_request(stt_pkg::FUNC_PROCESS, 48'd100, '0, '0);   // deadline equal to now: not expired
    send_request(stt_pkg::FUNC_PROCESS, 48'd101, '0, '0);   // newest first
    send_request(stt_pkg::FUNC_PROCESS, TMAX, '0, '0);      // fired timers stay quiet
    send_request(stt_pkg::FUNC_NEAREST, TMAX, '0, '0);
    send_request(stt_pkg::FUNC_REARM, 48'd10, 32'd5, 31'd2);
    send_request(stt_pkg::FUNC_DELETE, '0, '0, 31'd3);       // delete of a fired timer
    send_request(stt_pkg::FUNC_DELETE, '0, '0, 31'd3);
    send_request(stt_pkg::FUNC_NEAREST, '0, '0, '0);
    send_request(3'd5, '0, '0, '0);
    send_request(3'd7, TMAX, {stt_pkg::IVAL_W{1'b1}}, {stt_pkg::ID_W{1'b1}});
    send_request(stt_pkg::FUNC_PROCESS, TMAX, '0, '0);

    drain_responses();
    for (int n = 0; n < 190; n++) begin
      if (n == 80) begin
        // Fill the table past full, then expire it all in one request.
        for (int k = 0; k < 68; k++)
          send_request(stt_pkg::FUNC_ADD, clock_ms, $urandom_range(0, 500), '0);
        send_request(stt_pkg::FUNC_NEAREST, clock_ms, '0, '0);
        clock_ms = clock_ms + 1000;
        send_request(stt_pkg::FUNC_PROCESS, clock_ms, '0, '0);
        drain_responses();
      end
      if (n == 120) drain_responses();
      if (n == 150) quiet_phase = 1'b1;
      random_request();
    end
    req.valid <= 1'b0;
    drain_responses();
    repeat (300) @(posedge clk);
    if (table_model.mismatches == 0 && table_model.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
